// File: design/ffia_pkg.sv
// ----------------------------------------------------------------------------
// ffia_pkg
// Shared types and constants for the first-fit identifier allocator.
// ----------------------------------------------------------------------------
package ffia_pkg;

  localparam int ENTRIES = 4096;
  localparam int WORD_W  = 64;
  localparam int WORDS   = ENTRIES / WORD_W;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WADDR_W = $clog2(WORDS);
  localparam int ID_W    = 16;
  localparam int CNT_W   = 13;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 1;

  localparam logic [ID_W-1:0]  ID_BASE_RST = ID_W'(300);
  localparam logic [CNT_W-1:0] ACTIVE_RST  = CNT_W'(4096);

  localparam logic [CIDX_W-1:0] CFG_ID_BASE = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_ACTIVE  = 1'b1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK            = 2'd0,
    ST_NONE_FREE     = 2'd1,
    ST_NOT_ALLOCATED = 2'd2,
    ST_OUT_OF_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic start;
    logic next;
    logic check;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic count_zero;
    logic rel_oob;
    logic found;
    logic last_word;
    logic bit_set;
  } dp_stat_t;

endpackage

// File: design/ffia_req_if.sv
// ----------------------------------------------------------------------------
// ffia_req_if
// Request channel: operation and identifier to release.
// ----------------------------------------------------------------------------
interface ffia_req_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [ffia_pkg::ID_W-1:0] release_id;

  modport source (output valid, output operation, output release_id, input ready);
  modport sink   (input valid, input operation, input release_id, output ready);
endinterface

// File: design/ffia_rsp_if.sv
// ----------------------------------------------------------------------------
// ffia_rsp_if
// Response channel: identifier and status code.
// ----------------------------------------------------------------------------
interface ffia_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ffia_pkg::ID_W-1:0] result_id;
  logic [ffia_pkg::ST_W-1:0] status;

  modport source (output valid, output result_id, output status, input ready);
  modport sink   (input valid, input result_id, input status, output ready);
endinterface

// File: design/ffia_dp.sv
// ----------------------------------------------------------------------------
// ffia_dp
// Datapath: config registers, bitmap word memory, first-free search, result.
// ----------------------------------------------------------------------------
module ffia_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ffia_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ffia_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          req_operation,
  input  logic [ffia_pkg::ID_W-1:0]     req_release_id,
  input  ffia_pkg::ctrl_cmd_t           cmd,
  output ffia_pkg::dp_stat_t            stat,
  output logic [ffia_pkg::ID_W-1:0]     result_id,
  output logic [ffia_pkg::ST_W-1:0]     status
);
  import ffia_pkg::*;

  logic [ID_W-1:0]    id_base;
  logic [CNT_W-1:0]   active_entries;
  logic               op;
  logic [ID_W-1:0]    rid;
  logic [WADDR_W-1:0] waddr;
  logic [ID_W-1:0]    res_id;
  status_t            res_st;

  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORDS-1:0]   row_valid;
  logic [WORD_W-1:0]  rdata;
  logic               rvalid;

  logic [CNT_W-1:0]   count;
  logic [ID_W-1:0]    offset;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  elig;
  logic [WORD_W-1:0]  cand;
  logic [BIT_W-1:0]   free_idx;
  logic [BIT_W-1:0]   rel_bit;
  logic [WADDR_W-1:0] rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [WORD_W-1:0]  wdata;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base        <= ID_BASE_RST;
      active_entries <= ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_BASE: id_base        <= cfg_data[ID_W-1:0];
        CFG_ACTIVE:  active_entries <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign count  = (active_entries > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : active_entries;
  assign offset = rid - id_base;
  assign rel_bit = offset[BIT_W-1:0];
  assign word   = rvalid ? rdata : '0;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      elig[j] = CNT_W'({waddr, BIT_W'(j)}) < count;
    end
    cand = ~word & elig;
    free_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        free_idx = BIT_W'(j);
      end
    end
  end

  assign stat.is_alloc   = (op == OP_ALLOC);
  assign stat.count_zero = (count == '0);
  assign stat.rel_oob    = offset >= ID_W'(count);
  assign stat.found      = |cand;
  assign stat.last_word  = (CNT_W'({waddr, BIT_W'(0)}) + CNT_W'(WORD_W)) >= count;
  assign stat.bit_set    = word[rel_bit];

  // word read address
  always_comb begin
    rd_en   = cmd.start || cmd.next;
    rd_addr = waddr + WADDR_W'(1);
    if (cmd.start) begin
      rd_addr = (op == OP_ALLOC) ? '0 : offset[BIT_W +: WADDR_W];
    end
  end

  // word write on a successful check
  always_comb begin
    wr_en = 1'b0;
    wdata = word;
    if (cmd.check) begin
      if (op == OP_ALLOC) begin
        wr_en = stat.found;
        wdata = word | (WORD_W'(1) << free_idx);
      end else begin
        wr_en = stat.bit_set;
        wdata = word & ~(WORD_W'(1) << rel_bit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // rows never written read as free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rvalid <= row_valid[rd_addr];
      waddr  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_operation;
      rid <= req_release_id;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_id <= '0;
      res_st <= (op == OP_ALLOC) ? ST_NONE_FREE : ST_OUT_OF_RANGE;
    end else if (cmd.check) begin
      if (op == OP_ALLOC) begin
        res_id <= stat.found ? id_base + ID_W'({waddr, free_idx}) : '0;
        res_st <= stat.found ? ST_OK : ST_NONE_FREE;
      end else begin
        res_id <= stat.bit_set ? rid : '0;
        res_st <= stat.bit_set ? ST_OK : ST_NOT_ALLOCATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_id <= res_id;
      status    <= res_st;
    end
  end

endmodule

// File: design/ffia_ctrl.sv
// ----------------------------------------------------------------------------
// ffia_ctrl
// Controller: sequences accept, word scan, update and response handoff.
// ----------------------------------------------------------------------------
module ffia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  ffia_pkg::dp_stat_t  stat,
  output ffia_pkg::ctrl_cmd_t cmd
);
  import ffia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_CHECK = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.is_alloc ? stat.count_zero : stat.rel_oob) begin
          state_next = S_RESP;
        end else begin
          state_next = S_CHECK;
        end
        cmd.start = 1'b1;
      end
      S_CHECK: begin
        if (stat.is_alloc && !stat.found && !stat.last_word) begin
          cmd.next = 1'b1;
        end else begin
          cmd.check  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/first_fit_id_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_id_allocator_core
// First-fit identifier allocator over a 4096-entry bitmap.
// ----------------------------------------------------------------------------
// One item at a time. A release goes through an offset check, one bitmap
// word read and an update; an out-of-range release or an allocate with zero
// active entries goes from the check straight to the result. An allocate
// reads the bitmap one 64-bit word per cycle from word 0 until it finds a
// free entry or reaches the last active word. The result sits in an output
// register, and the next item is taken while it waits. The bitmap reads as
// all free after reset with no clearing pass.
module first_fit_id_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ffia_pkg::CIDX_W-1:0] cfg_index,
  input  logic [ffia_pkg::CFG_W-1:0]  cfg_data,
  ffia_req_if.sink                    req,
  ffia_rsp_if.source                  rsp
);
  import ffia_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ffia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffia_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_operation  (req.operation),
    .req_release_id (req.release_id),
    .cmd            (cmd),
    .stat           (stat),
    .result_id      (rsp.result_id),
    .status         (rsp.status)
  );

endmodule
